// ===== rtl/core/bfw_pkg.sv =====
// ----------------------------------------------------------------------------
// bfw_pkg: shared types and constants for the brush falloff weight block
// Item classes, queue entry layout and fixed-point constants.
// ----------------------------------------------------------------------------
package bfw_pkg;

  // Fixed-point one in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_RADIUS   = 2'd1;
  localparam logic [1:0] REG_FRACTION = 2'd2;

  // Falloff modes
  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_SMOOTH = 2'd2;

  // How the back end finishes one item
  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_ZERO,
    KIND_LINEAR,
    KIND_SMOOTH
  } kind_t;

  // One queued item: kind, ramp offset and ramp span
  typedef struct packed {
    kind_t       kind;
    logic [15:0] num;
    logic [15:0] span;
  } item_t;

  // Configuration as seen by the front end
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] radius;
    logic [16:0] fraction;
  } cfg_t;

endpackage

// ===== rtl/core/bfw_front.sv =====
// ----------------------------------------------------------------------------
// bfw_front: input capture and classification
// Registers a distance, works out the ramp bounds and sorts the item.
// ----------------------------------------------------------------------------
module bfw_front import bfw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [15:0] distance,
  input  cfg_t        cfg,
  output logic        push,
  output item_t       push_item
);

  logic        cap_valid;
  logic [15:0] cap_dist;
  logic [16:0] frac_sat;
  logic [16:0] frac_inv;
  logic [32:0] inner_prod;
  logic [15:0] inner;
  logic [15:0] span;
  logic        ramp_mode;

  // Capture register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= take;
    end
    if (take) begin
      cap_dist <= distance;
    end
  end

  // inner = floor(R*(1-F)), span = R - inner
  always_comb begin
    frac_sat   = (cfg.fraction > ONE_Q16) ? ONE_Q16 : cfg.fraction;
    frac_inv   = ONE_Q16 - frac_sat;
    inner_prod = {17'b0, cfg.radius} * {16'b0, frac_inv};
    inner      = inner_prod[31:16];
    span       = cfg.radius - inner;
    ramp_mode  = (cfg.mode == MODE_LINEAR) || (cfg.mode == MODE_SMOOTH);
  end

  // Classification
  always_comb begin
    push           = cap_valid;
    push_item.num  = cap_dist - inner;
    push_item.span = span;
    if (!ramp_mode || cap_dist < inner) begin
      push_item.kind = KIND_ONE;
    end else if (cap_dist > cfg.radius) begin
      push_item.kind = KIND_ZERO;
    end else if (span == 16'd0) begin
      push_item.kind = KIND_ONE;
    end else if (cfg.mode == MODE_LINEAR) begin
      push_item.kind = KIND_LINEAR;
    end else begin
      push_item.kind = KIND_SMOOTH;
    end
  end

endmodule

// ===== rtl/core/bfw_queue.sv =====
// ----------------------------------------------------------------------------
// bfw_queue: small item queue between front and back
// Four-entry FIFO; the back end drains one entry per cycle.
// ----------------------------------------------------------------------------
module bfw_queue import bfw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  not_empty,
  output logic  almost_full
);

  item_t       mem [0:3];
  logic [1:0]  wptr;
  logic [1:0]  rptr;
  logic [2:0]  count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  assign pop_item    = mem[rptr];
  assign not_empty   = (count != 3'd0);
  assign almost_full = (count >= 3'd2);

endmodule

// ===== rtl/core/bfw_back.sv =====
// ----------------------------------------------------------------------------
// bfw_back: ramp division and weight lookup
// Pipelined restoring divider (one quotient bit per stage), then cosine ROM.
// ----------------------------------------------------------------------------
module bfw_back import bfw_pkg::*; #(
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        done,
  output logic [16:0] weight
);

  localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int PW = 17 + IW + 1;
  localparam logic [IW-1:0] IDX_MAX = IW'(COS_TABLE_DEPTH);
  // Denominator of x = 1.45*i/DEPTH, written as 29*i/(20*DEPTH)
  localparam logic [63:0] X_DEN = 64'd20 * 64'(COS_TABLE_DEPTH);

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [16:0] rem;
    logic [15:0] span;
    logic [16:0] quo;
  } div_stage_t;

  // ROM entry: (cos((1.45*i/DEPTH)^3)+1)/2 via Taylor series in Q4.28
  function automatic logic [16:0] smooth_entry(input int idx);
    logic [63:0] x, x2, a, a2, term, prod, v;
    logic signed [63:0] acc, sum;
    begin
      x    = ((64'd29 * 64'(idx)) << 28) / X_DEN;
      x2   = (x * x) >> 28;
      a    = (x2 * x) >> 28;
      a2   = (a * a) >> 28;
      acc  = 64'sd1 <<< 28;
      term = 64'd1 << 28;
      for (int k = 1; k <= 12; k++) begin
        prod = (term * a2) >> 28;
        // term /= (2k-1)*(2k)
        case (k)
          1:       term = prod / 64'd2;
          2:       term = prod / 64'd12;
          3:       term = prod / 64'd30;
          4:       term = prod / 64'd56;
          5:       term = prod / 64'd90;
          6:       term = prod / 64'd132;
          7:       term = prod / 64'd182;
          8:       term = prod / 64'd240;
          9:       term = prod / 64'd306;
          10:      term = prod / 64'd380;
          11:      term = prod / 64'd462;
          default: term = prod / 64'd552;
        endcase
        if (k % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      sum = acc + (64'sd1 <<< 28);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = ($unsigned(sum) + 64'd4096) >> 13;
      if (v > 64'd65536) begin
        v = 64'd65536;
      end
      smooth_entry = v[16:0];
    end
  endfunction

  logic [16:0] rom [0:COS_TABLE_DEPTH];
  div_stage_t  stg [0:17];

  genvar gi;
  generate
    for (gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_rom
      assign rom[gi] = smooth_entry(gi);
    end
  endgenerate

  // Divider entry
  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else begin
      stg[0].valid <= in_valid;
    end
    stg[0].kind <= in_item.kind;
    stg[0].rem  <= {1'b0, in_item.num};
    stg[0].span <= in_item.span;
    stg[0].quo  <= 17'd0;
  end

  // One quotient bit per stage, MSB first
  generate
    for (gi = 0; gi < 17; gi++) begin : g_div
      logic [16:0] rem_sh;
      logic        ge;
      always_comb begin
        rem_sh = (gi == 0) ? stg[gi].rem : {stg[gi].rem[15:0], 1'b0};
        ge     = (rem_sh >= {1'b0, stg[gi].span});
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          stg[gi+1].valid <= 1'b0;
        end else begin
          stg[gi+1].valid <= stg[gi].valid;
        end
        stg[gi+1].kind <= stg[gi].kind;
        stg[gi+1].span <= stg[gi].span;
        stg[gi+1].rem  <= ge ? (rem_sh - {1'b0, stg[gi].span}) : rem_sh;
        stg[gi+1].quo  <= stg[gi].quo | (ge ? (17'd1 << (16 - gi)) : 17'd0);
      end
    end
  endgenerate

  // Table index = round(t * DEPTH), clamped
  logic [PW-1:0] idx_full;
  logic [IW-1:0] idx_c;
  always_comb begin
    idx_full = (PW'(stg[17].quo) * PW'(COS_TABLE_DEPTH) + PW'(32768)) >> 16;
    idx_c    = (idx_full > PW'(COS_TABLE_DEPTH)) ? IDX_MAX : idx_full[IW-1:0];
  end

  logic          ix_valid;
  kind_t         ix_kind;
  logic [IW-1:0] ix_idx;
  logic [16:0]   ix_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      ix_valid <= 1'b0;
    end else begin
      ix_valid <= stg[17].valid;
    end
    ix_kind <= stg[17].kind;
    ix_idx  <= idx_c;
    ix_lin  <= ONE_Q16 - stg[17].quo;
  end

  // ROM read and result register
  logic        out_valid;
  kind_t       out_kind;
  logic [16:0] out_rom;
  logic [16:0] out_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ix_valid;
    end
    out_kind <= ix_kind;
    out_rom  <= rom[ix_idx];
    out_lin  <= ix_lin;
  end

  always_comb begin
    done = out_valid;
    case (out_kind)
      KIND_ONE:    weight = ONE_Q16;
      KIND_ZERO:   weight = 17'd0;
      KIND_LINEAR: weight = out_lin;
      KIND_SMOOTH: weight = out_rom;
      default:     weight = ONE_Q16;
    endcase
  end

endmodule

// ===== rtl/core/brush_falloff_weight.sv =====
// ----------------------------------------------------------------------------
// brush_falloff_weight: terrain brush falloff weight
// Maps a distance from the brush center to a Q1.16 weight.
// ----------------------------------------------------------------------------
// One distance is taken per clock while busy is low; each result appears on
// weight with done high for exactly one cycle, in the order taken. The
// receiver cannot stall the block. Each distance passes the capture register,
// the queue, the divider entry register, the 17-stage pipelined divider that
// forms the ramp position, and the index and cosine ROM read registers.
// Configuration must be written through cfg_valid/cfg_ready only while no item
// is in flight; the block does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module brush_falloff_weight import bfw_pkg::*; #(
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] distance,
  output logic        done,
  output logic [16:0] weight,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [16:0] cfg_data
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  item_t pop_item;
  logic  not_empty;
  logic  almost_full;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_LINEAR;
      cfg.radius   <= 16'd1024;
      cfg.fraction <= 17'd32768;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_MODE:     cfg.mode     <= cfg_data[1:0];
        REG_RADIUS:   cfg.radius   <= cfg_data[15:0];
        REG_FRACTION: cfg.fraction <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign busy = almost_full;

  bfw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (start && !busy),
    .distance  (distance),
    .cfg       (cfg),
    .push      (push),
    .push_item (push_item)
  );

  bfw_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_item   (push_item),
    .pop         (not_empty),
    .pop_item    (pop_item),
    .not_empty   (not_empty),
    .almost_full (almost_full)
  );

  bfw_back #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (not_empty),
    .in_item  (pop_item),
    .done     (done),
    .weight   (weight)
  );

endmodule
